// File: sv/gimc_pkg.sv
// ============================================================================
// Grouped inverse-variance mean: shared definitions
// Field widths, item layouts and register indexes of the core.
// ============================================================================
package gimc_pkg;

    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int CNT_W    = 16;
    localparam int SD_W     = 31;
    localparam int ST_W     = 16;
    localparam int CELL_W   = 31;
    localparam int AZ_W     = 48;
    localparam int ACC_W    = 64;
    localparam int WSUM_W   = 63;
    localparam int SQ_W     = 2 * (3 * FRAC_W / 2) + 1;
    localparam int TDATA_W  = 336;
    localparam int CFG_AW   = 2;
    localparam int NQ       = 3;

    localparam logic [CFG_AW-1:0] REG_VEL_FLOOR = 2'd0;
    localparam logic [CFG_AW-1:0] REG_POW_FLOOR = 2'd1;
    localparam logic [CFG_AW-1:0] REG_WID_FLOOR = 2'd2;

    localparam logic [SD_W-1:0] FLOOR_RESET = SD_W'(1) << FRAC_W;

    typedef struct packed {
        logic [3:0]               pad;
        logic signed [DATA_W-1:0] mag_lon;
        logic signed [DATA_W-1:0] mag_lat;
        logic [SD_W-1:0]          width_sd;
        logic signed [DATA_W-1:0] width;
        logic [SD_W-1:0]          power_sd;
        logic signed [DATA_W-1:0] power;
        logic [SD_W-1:0]          velocity_sd;
        logic signed [DATA_W-1:0] velocity;
        logic signed [DATA_W-1:0] azimuth;
        logic [CELL_W-1:0]        cell_index;
        logic [ST_W-1:0]          station_id;
    } in_item_t;

    typedef struct packed {
        logic [3:0]               pad;
        logic signed [DATA_W-1:0] out_lon;
        logic signed [DATA_W-1:0] out_lat;
        logic [SD_W-1:0]          width_sigma;
        logic signed [DATA_W-1:0] mean_width;
        logic [SD_W-1:0]          power_sigma;
        logic signed [DATA_W-1:0] mean_power;
        logic [SD_W-1:0]          velocity_sigma;
        logic signed [DATA_W-1:0] mean_velocity;
        logic signed [DATA_W-1:0] mean_azimuth;
        logic [CELL_W-1:0]        out_cell;
        logic [ST_W-1:0]          out_station;
    } out_item_t;

endpackage

// File: sv/grouped_inverse_variance_mean_core.sv
// ============================================================================
// Grouped inverse-variance mean core
// Merges runs of radar vectors with equal station and cell into one item.
// ============================================================================
// One item at a time is taken. An item that extends a group is taken and
// passes the open state; then for each of the three quantities the square,
// a restoring division that forms the weight, the product and the
// saturating adds follow in turn. Closing a group adds one division for the
// azimuth mean, then per quantity two divisions and a square root, before
// the output register is loaded. All quotients come from one shared
// bit-serial divider, one quotient bit per cycle, so the divider sets the
// rate. A finished group waits in an output register while the next item
// is taken.
module grouped_inverse_variance_mean_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [gimc_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [gimc_pkg::SD_W-1:0]    cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // station_id, cell_index, azimuth, velocity, velocity_sd, power, power_sd,
    // width, width_sd, mag_lat, mag_lon, zero fill
    input  logic [gimc_pkg::TDATA_W-1:0] s_tdata,
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_station, out_cell, mean_azimuth, mean_velocity, velocity_sigma,
    // mean_power, power_sigma, mean_width, width_sigma, out_lat, out_lon,
    // zero fill
    output logic [gimc_pkg::TDATA_W-1:0] m_tdata,
    output logic                         m_tlast
);
    import gimc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_OPEN  = 11'b000_0000_0010,
        S_SQ    = 11'b000_0000_0100,
        S_WDIV  = 11'b000_0000_1000,
        S_PROD  = 11'b000_0001_0000,
        S_ADD   = 11'b000_0010_0000,
        S_EAZ   = 11'b000_0100_0000,
        S_EMEAN = 11'b000_1000_0000,
        S_EREC  = 11'b001_0000_0000,
        S_ESQRT = 11'b010_0000_0000,
        S_PUSH  = 11'b100_0000_0000
    } state_t;

    localparam logic [63:0]            RECIP_NUM = 64'd1 << (3 * FRAC_W);
    localparam logic [63:0]            WMAX64    = (64'd1 << (DATA_W - 1)) - 64'd1;
    localparam logic [CNT_W-1:0]       CNT_MAX   = '1;
    localparam logic signed [AZ_W:0]   AZ_POS    = (49'sd1 <<< (AZ_W - 1)) - 49'sd1;
    localparam logic signed [AZ_W:0]   AZ_NEG    = -AZ_POS;
    localparam logic signed [ACC_W:0]  ACC_POS   = (65'sd1 <<< (ACC_W - 1)) - 65'sd1;
    localparam logic signed [ACC_W:0]  ACC_NEG   = -ACC_POS;
    localparam logic [63:0]            WSUM_MAX  = (64'd1 << WSUM_W) - 64'd1;
    localparam logic [SQ_W-1:0]        SQ_TOP    = SQ_W'(1) << (SQ_W - 1);

    function automatic logic [63:0] mag64(input logic [63:0] v);
        mag64 = v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic [DATA_W-1:0] clamp_q(input logic neg, input logic [63:0] q);
        if (neg)
        begin
            clamp_q = (q > (64'd1 << (DATA_W - 1))) ? {1'b1, {(DATA_W - 1){1'b0}}}
                                                   : (~q[DATA_W-1:0] + 1'b1);
        end
        else
        begin
            clamp_q = (q > WMAX64) ? WMAX64[DATA_W-1:0] : q[DATA_W-1:0];
        end
    endfunction

    state_t              state_reg, state_next;
    logic [1:0]          idx_reg, idx_next;
    logic                emit_last_reg, emit_last_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                m_tlast_reg, m_tlast_next;
    logic                group_open_reg, group_open_next;
    logic [ST_W-1:0]     cur_station_reg, cur_station_next;
    logic [CELL_W-1:0]   cur_cell_reg, cur_cell_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic signed [AZ_W-1:0] az_sum_reg, az_sum_next;
    logic [ACC_W-1:0]    wsd_reg [NQ];
    logic [ACC_W-1:0]    wsd_next [NQ];
    logic [WSUM_W-1:0]   wsum_reg [NQ];
    logic [WSUM_W-1:0]   wsum_next [NQ];
    logic [DATA_W-1:0]   lat_reg, lat_next;
    logic [DATA_W-1:0]   lon_reg, lon_next;
    logic [SD_W-1:0]     floor_reg [NQ];

    logic [DATA_W-1:0]   item_az_reg;
    logic [DATA_W-1:0]   item_v_reg [NQ];
    logic [SD_W-1:0]     item_sd_reg [NQ];
    logic [ST_W-1:0]     item_st_reg;
    logic [CELL_W-1:0]   item_cell_reg;
    logic [DATA_W-1:0]   item_lat_reg, item_lon_reg;
    logic                item_eod_reg;

    logic [62:0]         div_rem_reg;
    logic [63:0]         div_quo_reg;
    logic [5:0]          div_cnt_reg;
    logic [SQ_W-1:0]     sq_x_reg;
    logic [SQ_W:0]       sq_r_reg;
    logic [SQ_W-1:0]     sq_bit_reg;
    logic [62:0]         prod_reg;
    logic [SD_W-1:0]     w_reg;
    logic [DATA_W-1:0]   res_az_reg;
    logic [DATA_W-1:0]   res_mean_reg [NQ];
    logic [SD_W-1:0]     res_sig_reg [NQ];
    out_item_t           out_reg;

    in_item_t            item_in;
    logic                accept;
    logic                div_load, sq_load, out_load, clear;
    logic [63:0]         div_load_val;
    logic [62:0]         div_d;
    logic [63:0]         rem_sh;
    logic                div_ge, div_last, div_busy;
    logic [62:0]         rem_new;
    logic [63:0]         quo_new;
    logic [SQ_W:0]       sq_t;
    logic                sq_ge;
    logic [SQ_W-1:0]     sq_x_new;
    logic [SQ_W:0]       sq_r_new;
    logic [SD_W-1:0]     sd_sel, fl_sel, s_eff, w_clamped;
    logic [DATA_W-1:0]   v_sel, v_mag, mul_a;
    logic [SD_W-1:0]     mul_b;
    logic [62:0]         mul_p;
    logic [WSUM_W-1:0]   wsum_sel, wsum_or1;
    logic [CNT_W-1:0]    cnt_or1;
    logic signed [AZ_W:0]   az_sum49;
    logic signed [AZ_W-1:0] az_sat;
    logic [ACC_W-1:0]    b_term;
    logic signed [ACC_W:0]  wsd65;
    logic [ACC_W-1:0]    wsd_sat;
    logic [63:0]         wsum64;
    logic [WSUM_W-1:0]   wsum_sat;
    logic [63:0]         next_mean_mag;

    assign item_in  = in_item_t'(s_tdata);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = out_reg;

    // Shared restoring divider, one quotient bit per cycle.
    assign wsum_sel = wsum_reg[idx_reg];
    assign wsum_or1 = (wsum_sel == '0) ? WSUM_W'(1) : wsum_sel;
    assign cnt_or1  = (count_reg == '0) ? CNT_W'(1) : count_reg;

    always_comb
    begin
        unique case (state_reg)
            S_WDIV:          div_d = prod_reg;
            S_EAZ:           div_d = 63'(cnt_or1);
            S_EMEAN, S_EREC: div_d = wsum_or1;
            default:         div_d = '0;
        endcase
    end

    assign div_busy = (state_reg == S_WDIV) || (state_reg == S_EAZ) ||
                      (state_reg == S_EMEAN) || (state_reg == S_EREC);
    assign rem_sh   = {div_rem_reg, div_quo_reg[63]};
    assign div_ge   = rem_sh >= {1'b0, div_d};
    assign rem_new  = div_ge ? 63'(rem_sh - {1'b0, div_d}) : rem_sh[62:0];
    assign quo_new  = {div_quo_reg[62:0], div_ge};
    assign div_last = (div_cnt_reg == 6'd63);

    // Integer square root, two radicand bits per cycle.
    assign sq_t     = sq_r_reg + {1'b0, sq_bit_reg};
    assign sq_ge    = {1'b0, sq_x_reg} >= sq_t;
    assign sq_x_new = sq_ge ? SQ_W'(sq_x_reg - sq_t[SQ_W-1:0]) : sq_x_reg;
    assign sq_r_new = sq_ge ? ((sq_r_reg >> 1) + {1'b0, sq_bit_reg}) : (sq_r_reg >> 1);

    // Weight and product path.
    assign sd_sel    = item_sd_reg[idx_reg];
    assign fl_sel    = floor_reg[idx_reg];
    assign s_eff     = (sd_sel < fl_sel) ? fl_sel : sd_sel;
    assign w_clamped = (quo_new == '0) ? SD_W'(1) :
                       ((quo_new > WMAX64) ? WMAX64[SD_W-1:0] : quo_new[SD_W-1:0]);
    assign v_sel     = item_v_reg[idx_reg];
    assign v_mag     = v_sel[DATA_W-1] ? (~v_sel + 1'b1) : v_sel;
    assign mul_a     = (state_reg == S_SQ) ? {1'b0, s_eff} : v_mag;
    assign mul_b     = (state_reg == S_SQ) ? s_eff : w_reg;
    assign mul_p     = 63'(mul_a) * 63'(mul_b);

    // Saturating accumulators.
    assign az_sum49 = {az_sum_reg[AZ_W-1], az_sum_reg} +
                      {{(AZ_W - DATA_W + 1){item_az_reg[DATA_W-1]}}, item_az_reg};
    assign az_sat   = (az_sum49 > AZ_POS) ? AZ_POS[AZ_W-1:0] :
                      ((az_sum49 < AZ_NEG) ? AZ_NEG[AZ_W-1:0] : az_sum49[AZ_W-1:0]);
    assign b_term   = v_sel[DATA_W-1] ? (~{1'b0, prod_reg} + 64'd1) : {1'b0, prod_reg};
    assign wsd65    = {wsd_reg[idx_reg][ACC_W-1], wsd_reg[idx_reg]} + {b_term[ACC_W-1], b_term};
    assign wsd_sat  = (wsd65 > ACC_POS) ? ACC_POS[ACC_W-1:0] :
                      ((wsd65 < ACC_NEG) ? ACC_NEG[ACC_W-1:0] : wsd65[ACC_W-1:0]);
    assign wsum64   = {1'b0, wsum_sel} + 64'(w_reg);
    assign wsum_sat = (wsum64 > WSUM_MAX) ? WSUM_MAX[WSUM_W-1:0] : wsum64[WSUM_W-1:0];
    assign next_mean_mag = (idx_reg == 2'd0) ? mag64(wsd_reg[1]) : mag64(wsd_reg[2]);

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        emit_last_next   = emit_last_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tlast_next     = m_tlast_reg;
        group_open_next  = group_open_reg;
        cur_station_next = cur_station_reg;
        cur_cell_next    = cur_cell_reg;
        count_next       = count_reg;
        az_sum_next      = az_sum_reg;
        lat_next         = lat_reg;
        lon_next         = lon_reg;
        for (int i = 0; i < NQ; i++)
        begin
            wsd_next[i]  = wsd_reg[i];
            wsum_next[i] = wsum_reg[i];
        end
        div_load     = 1'b0;
        div_load_val = mag64(64'(az_sum_reg));
        sq_load      = 1'b0;
        out_load     = 1'b0;
        clear        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (group_open_reg && (item_in.station_id != cur_station_reg ||
                                           item_in.cell_index != cur_cell_reg))
                    begin
                        emit_last_next = 1'b0;
                        div_load       = 1'b1;
                        state_next     = S_EAZ;
                    end
                    else
                    begin
                        state_next = S_OPEN;
                    end
                end
            end
            S_OPEN:
            begin
                if (!group_open_reg)
                begin
                    group_open_next  = 1'b1;
                    cur_station_next = item_st_reg;
                    cur_cell_next    = item_cell_reg;
                    lat_next         = item_lat_reg;
                    lon_next         = item_lon_reg;
                end
                if (count_reg != CNT_MAX)
                begin
                    count_next  = count_reg + 1'b1;
                    az_sum_next = az_sat;
                    idx_next    = 2'd0;
                    state_next  = S_SQ;
                end
                else if (item_eod_reg)
                begin
                    emit_last_next = 1'b1;
                    div_load       = 1'b1;
                    state_next     = S_EAZ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SQ:
            begin
                div_load     = 1'b1;
                div_load_val = RECIP_NUM;
                state_next   = S_WDIV;
            end
            S_WDIV:
            begin
                if (div_last)
                begin
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                wsd_next[idx_reg]  = wsd_sat;
                wsum_next[idx_reg] = wsum_sat;
                if (idx_reg == 2'd2)
                begin
                    if (item_eod_reg)
                    begin
                        emit_last_next = 1'b1;
                        div_load       = 1'b1;
                        state_next     = S_EAZ;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SQ;
                end
            end
            S_EAZ:
            begin
                if (div_last)
                begin
                    idx_next     = 2'd0;
                    div_load     = 1'b1;
                    div_load_val = mag64(wsd_reg[0]);
                    state_next   = S_EMEAN;
                end
            end
            S_EMEAN:
            begin
                if (div_last)
                begin
                    div_load     = 1'b1;
                    div_load_val = RECIP_NUM;
                    state_next   = S_EREC;
                end
            end
            S_EREC:
            begin
                if (div_last)
                begin
                    sq_load    = 1'b1;
                    state_next = S_ESQRT;
                end
            end
            S_ESQRT:
            begin
                if (sq_bit_reg[0])
                begin
                    if (idx_reg == 2'd2)
                    begin
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        idx_next     = idx_reg + 1'b1;
                        div_load     = 1'b1;
                        div_load_val = next_mean_mag;
                        state_next   = S_EMEAN;
                    end
                end
            end
            S_PUSH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load      = 1'b1;
                    clear         = 1'b1;
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = emit_last_reg;
                    state_next    = emit_last_reg ? S_IDLE : S_OPEN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (clear)
        begin
            group_open_next  = 1'b0;
            cur_station_next = '0;
            cur_cell_next    = '0;
            count_next       = '0;
            az_sum_next      = '0;
            lat_next         = '0;
            lon_next         = '0;
            for (int i = 0; i < NQ; i++)
            begin
                wsd_next[i]  = '0;
                wsum_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            emit_last_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            m_tlast_reg     <= 1'b0;
            group_open_reg  <= 1'b0;
            cur_station_reg <= '0;
            cur_cell_reg    <= '0;
            count_reg       <= '0;
            az_sum_reg      <= '0;
            lat_reg         <= '0;
            lon_reg         <= '0;
            for (int i = 0; i < NQ; i++)
            begin
                wsd_reg[i]   <= '0;
                wsum_reg[i]  <= '0;
                floor_reg[i] <= FLOOR_RESET;
            end
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            emit_last_reg   <= emit_last_next;
            m_tvalid_reg    <= m_tvalid_next;
            m_tlast_reg     <= m_tlast_next;
            group_open_reg  <= group_open_next;
            cur_station_reg <= cur_station_next;
            cur_cell_reg    <= cur_cell_next;
            count_reg       <= count_next;
            az_sum_reg      <= az_sum_next;
            lat_reg         <= lat_next;
            lon_reg         <= lon_next;
            for (int i = 0; i < NQ; i++)
            begin
                wsd_reg[i]  <= wsd_next[i];
                wsum_reg[i] <= wsum_next[i];
            end
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_VEL_FLOOR: floor_reg[0] <= cfg_wdata;
                    REG_POW_FLOOR: floor_reg[1] <= cfg_wdata;
                    REG_WID_FLOOR: floor_reg[2] <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_st_reg    <= item_in.station_id;
            item_cell_reg  <= item_in.cell_index;
            item_az_reg    <= item_in.azimuth;
            item_v_reg[0]  <= item_in.velocity;
            item_v_reg[1]  <= item_in.power;
            item_v_reg[2]  <= item_in.width;
            item_sd_reg[0] <= item_in.velocity_sd;
            item_sd_reg[1] <= item_in.power_sd;
            item_sd_reg[2] <= item_in.width_sd;
            item_lat_reg   <= item_in.mag_lat;
            item_lon_reg   <= item_in.mag_lon;
            item_eod_reg   <= s_tlast;
        end
        if (div_load)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= div_load_val;
            div_cnt_reg <= '0;
        end
        else if (div_busy)
        begin
            div_rem_reg <= rem_new;
            div_quo_reg <= quo_new;
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (sq_load)
        begin
            sq_x_reg   <= quo_new[SQ_W-1:0];
            sq_r_reg   <= '0;
            sq_bit_reg <= SQ_TOP;
        end
        else if (state_reg == S_ESQRT)
        begin
            sq_x_reg   <= sq_x_new;
            sq_r_reg   <= sq_r_new;
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (state_reg == S_SQ || state_reg == S_PROD)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == S_WDIV && div_last)
        begin
            w_reg <= w_clamped;
        end
        if (state_reg == S_EAZ && div_last)
        begin
            res_az_reg <= clamp_q(az_sum_reg[AZ_W-1], quo_new);
        end
        if (state_reg == S_EMEAN && div_last)
        begin
            res_mean_reg[idx_reg] <= clamp_q(wsd_reg[idx_reg][ACC_W-1], quo_new);
        end
        if (state_reg == S_ESQRT && sq_bit_reg[0])
        begin
            res_sig_reg[idx_reg] <= sq_r_new[SD_W-1:0];
        end
        if (out_load)
        begin
            out_reg.pad            <= '0;
            out_reg.out_lon        <= lon_reg;
            out_reg.out_lat        <= lat_reg;
            out_reg.width_sigma    <= res_sig_reg[2];
            out_reg.mean_width     <= res_mean_reg[2];
            out_reg.power_sigma    <= res_sig_reg[1];
            out_reg.mean_power     <= res_mean_reg[1];
            out_reg.velocity_sigma <= res_sig_reg[0];
            out_reg.mean_velocity  <= res_mean_reg[0];
            out_reg.mean_azimuth   <= res_az_reg;
            out_reg.out_cell       <= cur_cell_reg;
            out_reg.out_station    <= cur_station_reg;
        end
    end

`ifndef SYNTHESIS
    a_push_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_PUSH))
        else $error("Output item raised outside the push state.");

    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (group_open_reg == (count_reg != '0)))
        else $error("Open group flag disagrees with the group count.");

    a_weight_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROD) |-> (w_reg != '0))
        else $error("Weight of zero reached the product stage.");

    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wsd_reg[0] != {1'b1, 63'd0}) && (wsd_reg[1] != {1'b1, 63'd0}) &&
        (wsd_reg[2] != {1'b1, 63'd0}))
        else $error("Weighted sum left its saturation range.");
`endif

endmodule
